FILE: rtl/core/assert_macros.svh
// Assertion macros for the port-level checker of the codec.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds at a rising clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

FILE: rtl/core/leb_pkg.sv
// Types and constants of the LEB128 codec.
package leb_pkg;

  // Default limit on bytes per value.
  localparam int unsigned LEB_MAX_BYTES = 10;

  // Field widths.
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COUNT_W = 4;
  localparam int unsigned AMT_W   = 6;   // shift amount into a 64-bit word
  localparam int unsigned POS_W   = 7;   // running bit position, up to 70
  localparam int unsigned GROUP_W = 7;   // payload bits per encoded byte

  // Stream payload widths.
  localparam int unsigned S_TDATA_W = 72;
  localparam int unsigned M_TDATA_W = 80;

  typedef enum logic [1:0] {
    OP_DEC_U = 2'd0,
    OP_DEC_S = 2'd1,
    OP_ENC_U = 2'd2,
    OP_ENC_S = 2'd3
  } leb_op_e;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DEC  = 5'b00010,
    ST_SEXT = 5'b00100,
    ST_EMIT = 5'b01000,
    ST_ENC  = 5'b10000
  } leb_state_e;

  // Request to the shared shifter.
  typedef struct packed {
    logic [VALUE_W-1:0] operand;
    logic [AMT_W-1:0]   amount;
    logic               left;
    logic               arith;
  } leb_shift_req_t;

endpackage

FILE: rtl/core/leb_shifter.sv
// Shared 64-bit shifter: left, logical right or arithmetic right.
module leb_shifter
  import leb_pkg::*;
(
  input  leb_shift_req_t     req_i,
  output logic [VALUE_W-1:0] result_o
);

  // Pick direction and fill
  always_comb begin
    if (req_i.left) begin
      result_o = req_i.operand << req_i.amount;
    end else if (req_i.arith) begin
      result_o = VALUE_W'($signed(req_i.operand) >>> req_i.amount);
    end else begin
      result_o = req_i.operand >> req_i.amount;
    end
  end

endmodule

FILE: rtl/core/leb128_codec.sv
// Top level of the LEB128 codec: sequencer, state and output register.
//
// LEB128 codec, unsigned and signed, chosen per input beat by tuser. A decode
// beat carries one encoded byte; a byte with bit 7 clear returns the value and
// its byte count, a continuing byte at the byte limit or marked by tlast
// returns the partial value with status 1. An encode beat carries a 64-bit
// value and returns one beat per encoded byte, tlast on the final one, status
// 1 if the value was cut at the byte limit. The block takes one input beat at
// a time: a continuing decode byte that leaves the value open passes through
// the decode state back to idle, one that ends or cuts off the value passes
// through decode, sign extension if needed, and emit, which waits on output,
// and an encode emits one byte each time the output slot is free. All steps
// use the single shared shifter, which merges one payload group, sign-extends,
// or steps the encode value by 7 bits. No clearing pass is needed after reset.
module leb128_codec
  import leb_pkg::*;
#(
  parameter int unsigned MAX_BYTES = LEB_MAX_BYTES
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Input stream
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,  // [7:0] data_byte, [71:8] data_value
  input  logic [1:0]           s_axis_tuser_i,  // [1:0] opcode
  input  logic                 s_axis_tlast_i,  // buffer_end
  // Output stream
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [M_TDATA_W-1:0] m_axis_tdata_o,  // [7:0] out_byte, [71:8] out_value,
                                                // [75:72] byte_count, [79:76] zero
  output logic                 m_axis_tuser_o,  // status
  output logic                 m_axis_tlast_o   // last
);

  localparam logic [COUNT_W-1:0] MaxCnt = COUNT_W'(MAX_BYTES);
  localparam logic [POS_W-1:0]   WordW  = POS_W'(VALUE_W);

  leb_state_e state_q, state_d;

  // Captured input beat
  leb_op_e            op_q;
  logic [BYTE_W-1:0]  byte_q;
  logic               bend_q;
  logic [VALUE_W-1:0] val_q, val_d;

  // Decode state
  logic [VALUE_W-1:0] acc_q, acc_d;
  logic [COUNT_W-1:0] cnt_q, cnt_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic               err_q, err_d;

  // Encode byte counter
  logic [COUNT_W-1:0] enc_cnt_q, enc_cnt_d;

  // Output register
  logic               m_valid_q, m_valid_d;
  logic [BYTE_W-1:0]  o_byte_q, o_byte_d;
  logic [VALUE_W-1:0] o_value_q, o_value_d;
  logic [COUNT_W-1:0] o_count_q, o_count_d;
  logic               o_last_q, o_last_d;
  logic               o_status_q, o_status_d;

  leb_shift_req_t     sh_req;
  logic [VALUE_W-1:0] sh_res;

  logic s_fire, slot_free, load;
  logic is_enc;
  logic [COUNT_W-1:0] cnt_inc;
  logic [GROUP_W-1:0] grp;
  logic neg, done, limit;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign slot_free       = !m_valid_q || m_axis_tready_i;
  assign is_enc          = (leb_op_e'(s_axis_tuser_i) == OP_ENC_U) ||
                           (leb_op_e'(s_axis_tuser_i) == OP_ENC_S);
  assign cnt_inc         = cnt_q + COUNT_W'(1);

  leb_shifter u_shifter (
    .req_i    (sh_req),
    .result_o (sh_res)
  );

  // Steer the shared shifter by state
  always_comb begin
    sh_req.operand = val_q;
    sh_req.amount  = AMT_W'(GROUP_W);
    sh_req.left    = 1'b0;
    sh_req.arith   = (op_q == OP_ENC_S);
    case (state_q)
      ST_DEC: begin
        sh_req.operand = {{(VALUE_W-GROUP_W){1'b0}}, byte_q[GROUP_W-1:0]};
        sh_req.amount  = pos_q[AMT_W-1:0];
        sh_req.left    = 1'b1;
      end
      ST_SEXT: begin
        sh_req.operand = '1;
        sh_req.amount  = pos_q[AMT_W-1:0];
        sh_req.left    = 1'b1;
      end
      default: ;
    endcase
  end

  // Encode stop rules for the current group
  assign grp   = val_q[GROUP_W-1:0];
  assign neg   = grp[GROUP_W-1];
  assign done  = (op_q == OP_ENC_S) ? ((sh_res == '1 && neg) || (sh_res == '0 && !neg))
                                    : (sh_res == '0);
  assign limit = (enc_cnt_q + COUNT_W'(1)) >= MaxCnt;

  // Sequencer
  always_comb begin
    state_d    = state_q;
    val_d      = val_q;
    acc_d      = acc_q;
    cnt_d      = cnt_q;
    pos_d      = pos_q;
    err_d      = err_q;
    enc_cnt_d  = enc_cnt_q;
    load       = 1'b0;
    o_byte_d   = o_byte_q;
    o_value_d  = o_value_q;
    o_count_d  = o_count_q;
    o_last_d   = o_last_q;
    o_status_d = o_status_q;
    case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          val_d     = s_axis_tdata_i[S_TDATA_W-1:BYTE_W];
          enc_cnt_d = '0;
          state_d   = is_enc ? ST_ENC : ST_DEC;
        end
      end
      // Merge one payload group at the running position
      ST_DEC: begin
        if (pos_q < WordW) begin
          acc_d = acc_q | sh_res;
        end
        cnt_d = cnt_inc;
        pos_d = pos_q + POS_W'(GROUP_W);
        err_d = 1'b0;
        if (!byte_q[BYTE_W-1]) begin
          if (op_q == OP_DEC_S && pos_d < WordW && byte_q[GROUP_W-1]) begin
            state_d = ST_SEXT;
          end else begin
            state_d = ST_EMIT;
          end
        end else if (cnt_inc >= MaxCnt || bend_q) begin
          err_d   = 1'b1;
          state_d = ST_EMIT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      // Fill the bits above the last payload group with ones
      ST_SEXT: begin
        acc_d   = acc_q | sh_res;
        state_d = ST_EMIT;
      end
      // Hand the decoded value to the output and clear the decode state
      ST_EMIT: begin
        if (slot_free) begin
          load       = 1'b1;
          o_byte_d   = '0;
          o_value_d  = acc_q;
          o_count_d  = cnt_q;
          o_last_d   = 1'b0;
          o_status_d = err_q;
          acc_d      = '0;
          cnt_d      = '0;
          pos_d      = '0;
          state_d    = ST_IDLE;
        end
      end
      // Emit one encoded byte and advance the value by one group
      ST_ENC: begin
        if (slot_free) begin
          load       = 1'b1;
          o_byte_d   = {!(done || limit), grp};
          o_value_d  = '0;
          o_count_d  = '0;
          o_last_d   = done || limit;
          o_status_d = !done && limit;
          val_d      = sh_res;
          enc_cnt_d  = enc_cnt_q + COUNT_W'(1);
          if (done || limit) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end else begin
      m_valid_d = m_valid_q;
    end
  end

  // Control and decode state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      acc_q     <= '0;
      cnt_q     <= '0;
      pos_q     <= '0;
      err_q     <= 1'b0;
      enc_cnt_q <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      acc_q     <= acc_d;
      cnt_q     <= cnt_d;
      pos_q     <= pos_d;
      err_q     <= err_d;
      enc_cnt_q <= enc_cnt_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      op_q   <= leb_op_e'(s_axis_tuser_i);
      byte_q <= s_axis_tdata_i[BYTE_W-1:0];
      bend_q <= s_axis_tlast_i;
    end
    val_q      <= val_d;
    o_byte_q   <= o_byte_d;
    o_value_q  <= o_value_d;
    o_count_q  <= o_count_d;
    o_last_q   <= o_last_d;
    o_status_q <= o_status_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {{(M_TDATA_W-BYTE_W-VALUE_W-COUNT_W){1'b0}},
                            o_count_q, o_value_q, o_byte_q};
  assign m_axis_tuser_o  = o_status_q;
  assign m_axis_tlast_o  = o_last_q;

endmodule

FILE: rtl/core/leb_checker.sv
// Port-level checks of the LEB128 codec, bound to its top level.
`include "assert_macros.svh"

module leb_checker
  import leb_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid_i,
  input logic                 s_axis_tready_o,
  input logic [S_TDATA_W-1:0] s_axis_tdata_i,
  input logic [1:0]           s_axis_tuser_i,
  input logic                 s_axis_tlast_i,
  input logic                 m_axis_tvalid_o,
  input logic                 m_axis_tready_i,
  input logic [M_TDATA_W-1:0] m_axis_tdata_o,
  input logic                 m_axis_tuser_o,
  input logic                 m_axis_tlast_o
);

  // Hold a stalled output beat
  `ASSERT_CLK(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o) && $stable(m_axis_tuser_o), "output beat changed while stalled")

  // One input beat at a time: busy right after an accepted beat
  `ASSERT_CLK(a_busy_after_accept, s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o, "input accepted on back-to-back cycles")

  // A decode result never carries an encoded byte or the last mark
  `ASSERT_CLK(a_dec_clean, m_axis_tvalid_o && m_axis_tdata_o[75:72] != 4'd0 |-> !m_axis_tlast_o && m_axis_tdata_o[7:0] == 8'd0, "decode result carries encode fields")

  // The final encoded byte has its continuation bit clear
  `ASSERT_NEVER(a_last_stop, m_axis_tvalid_o && m_axis_tlast_o && m_axis_tdata_o[7], "last encoded byte marked as continuing")

endmodule

bind leb128_codec leb_checker u_leb_checker (.*);

FILE: tb/sv/leb128_result_checker.sv
// Result checker for the LEB128 codec: predicts every output beat and compares it.
`timescale 1ns / 1ps

module leb128_result_checker
  import leb_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Input stream, watched
  input  logic                 s_tvalid_i,
  input  logic                 s_tready_i,
  input  logic [S_TDATA_W-1:0] s_tdata_i,  // [7:0] data_byte, [71:8] data_value
  input  logic [1:0]           s_tuser_i,  // [1:0] opcode
  input  logic                 s_tlast_i,  // buffer_end
  // Output stream, watched
  input  logic                 m_tvalid_i,
  input  logic                 m_tready_i,
  input  logic [M_TDATA_W-1:0] m_tdata_i,  // [7:0] out_byte, [71:8] out_value,
                                           // [75:72] byte_count, [79:76] zero
  input  logic                 m_tuser_i,  // status
  input  logic                 m_tlast_i,  // last
  // Verdict inputs for the top
  output int unsigned          errors_o,
  output int unsigned          pending_o
);

  typedef struct packed {
    logic [BYTE_W-1:0]  code_byte;
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] count;
    logic               last;
    logic               status;
  } leb_result_t;

  leb_result_t        expected_q[$];
  logic [VALUE_W-1:0] dec_acc;
  int unsigned        dec_seen;
  int unsigned        n_fail;

  // Split a value into 7-bit groups; the signed stop rule looks at the group's sign bit
  function automatic void encode_value(input logic [VALUE_W-1:0] value, input logic signed_mode);
    logic [VALUE_W-1:0] rest;
    logic [6:0]         group;
    logic               done;
    logic               finished;
    int unsigned        k;
    leb_result_t        r;
    rest     = value;
    k        = 0;
    finished = 1'b0;
    while (!finished) begin
      group = rest[6:0];
      if (signed_mode) begin
        rest = $signed(rest) >>> 7;
        done = (rest == '1 && group[6]) || (rest == '0 && !group[6]);
      end else begin
        rest = rest >> 7;
        done = (rest == '0);
      end
      r = '0;
      if (done || k + 1 >= LEB_MAX_BYTES) begin
        // final byte; cut at the byte limit flags status
        r.code_byte = {1'b0, group};
        r.last      = 1'b1;
        r.status    = !done;
        finished    = 1'b1;
      end else begin
        r.code_byte = {1'b1, group};
      end
      expected_q.push_back(r);
      k++;
    end
  endfunction

  // Merge one encoded byte into the pending value
  function automatic void decode_byte(input leb_op_e op, input logic [7:0] code,
                                      input logic buf_end);
    int unsigned shift;
    leb_result_t r;
    shift = 7 * dec_seen;
    if (shift < 64) dec_acc |= {57'd0, code[6:0]} << shift;
    dec_seen++;
    r = '0;
    if (!code[7]) begin
      // value ends; signedness comes from the terminating byte
      if (op == OP_DEC_S && 7 * dec_seen < 64 && code[6]) begin
        dec_acc |= {VALUE_W{1'b1}} << (7 * dec_seen);
      end
      r.value = dec_acc;
      r.count = dec_seen[COUNT_W-1:0];
      expected_q.push_back(r);
      dec_acc  = '0;
      dec_seen = 0;
    end else if (dec_seen >= LEB_MAX_BYTES || buf_end) begin
      // unterminated: return the partial value with status set
      r.value  = dec_acc;
      r.count  = dec_seen[COUNT_W-1:0];
      r.status = 1'b1;
      expected_q.push_back(r);
      dec_acc  = '0;
      dec_seen = 0;
    end
  endfunction

  always @(posedge clk_i) begin : watch
    leb_result_t got;
    leb_result_t want;
    leb_op_e     op;
    if (!rst_ni) begin
      expected_q.delete();
      dec_acc  = '0;
      dec_seen = 0;
      n_fail   = 0;
    end else begin
      // Compare an accepted output beat with the oldest expectation
      if (m_tvalid_i && m_tready_i) begin
        got.code_byte = m_tdata_i[7:0];
        got.value     = m_tdata_i[71:8];
        got.count     = m_tdata_i[75:72];
        got.last      = m_tlast_i;
        got.status    = m_tuser_i;
        if (expected_q.size() == 0) begin
          n_fail++;
          if (n_fail <= 10) begin
            $display("%0t: unexpected beat: byte %h value %h count %0d last %b status %b",
                     $realtime, got.code_byte, got.value, got.count, got.last, got.status);
          end
        end else begin
          want = expected_q.pop_front();
          if (got !== want || m_tdata_i[79:76] !== 4'd0) begin
            n_fail++;
            if (n_fail <= 10) begin
              $display("%0t: mismatch exp/got: byte %h/%h value %h/%h count %0d/%0d",
                       $realtime, want.code_byte, got.code_byte, want.value, got.value,
                       want.count, got.count);
              $display("  last %b/%b status %b/%b pad 0/%h",
                       want.last, got.last, want.status, got.status, m_tdata_i[79:76]);
            end
          end
        end
      end
      // Predict the results of an accepted input beat
      if (s_tvalid_i && s_tready_i) begin
        op = leb_op_e'(s_tuser_i);
        if (op == OP_ENC_U || op == OP_ENC_S) begin
          encode_value(s_tdata_i[71:8], op == OP_ENC_S);
        end else begin
          decode_byte(op, s_tdata_i[7:0], s_tlast_i);
        end
      end
    end
    errors_o  <= n_fail;
    pending_o <= expected_q.size();
  end

endmodule

FILE: tb/sv/tb_leb128_codec.sv
// Testbench top for the LEB128 codec: clock, reset, stimulus, output stalls and verdict.
`timescale 1ns / 1ps

module tb_leb128_codec;
  import leb_pkg::*;

  logic                 clk;
  logic                 rst_n;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;
  logic [1:0]           s_tuser;
  logic                 s_tlast;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tuser;
  logic                 m_tlast;
  int unsigned          fail_count;
  int unsigned          pending;

  logic                 quiet;         // no idling on either side
  logic                 hold_off_req;  // ask the sink for a long stall
  int unsigned          src_idle_pct;
  int unsigned          beats_sent;

  leb128_codec uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  leb128_result_checker chk (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .s_tvalid_i (s_tvalid),
    .s_tready_i (s_tready),
    .s_tdata_i  (s_tdata),
    .s_tuser_i  (s_tuser),
    .s_tlast_i  (s_tlast),
    .m_tvalid_i (m_tvalid),
    .m_tready_i (m_tready),
    .m_tdata_i  (m_tdata),
    .m_tuser_i  (m_tuser),
    .m_tlast_i  (m_tlast),
    .errors_o   (fail_count),
    .pending_o  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Offer one input beat, with an optional idle burst first; returns at the falling edge
  task automatic send_beat(input leb_op_e op, input logic [7:0] code,
                           input logic [63:0] value, input logic buf_end);
    if ($urandom_range(0, 31) == 0) src_idle_pct = $urandom_range(0, 2) * 20;
    if (!quiet && $urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {value, code};
    s_tuser  = op;
    s_tlast  = buf_end;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    beats_sent++;
    @(negedge clk);
  endtask

  // Encode beat with a value of random magnitude; signed ones may be negative
  task automatic send_encode();
    leb_op_e     op;
    logic [63:0] value;
    op    = $urandom_range(0, 1) ? OP_ENC_S : OP_ENC_U;
    value = rand64() >> $urandom_range(0, 63);
    if (op == OP_ENC_S && $urandom_range(0, 1)) value = ~value;
    send_beat(op, 8'($urandom), value, 1'($urandom_range(0, 1)));
  endtask

  // Well-formed encoded value, sometimes left unterminated, sometimes with modes mixed
  task automatic send_decode_run();
    int unsigned len;
    int unsigned i;
    int unsigned pick;
    logic        open_end;
    logic        is_final;
    leb_op_e     op;
    logic [7:0]  code;
    pick = $urandom_range(0, 99);
    if (pick < 50)      len = $urandom_range(1, 3);
    else if (pick < 85) len = $urandom_range(4, 9);
    else                len = 10;
    open_end = ($urandom_range(0, 9) == 0);
    op       = $urandom_range(0, 1) ? OP_DEC_S : OP_DEC_U;
    for (i = 0; i < len; i++) begin
      is_final = (i == len - 1);
      if ($urandom_range(0, 9) == 0) op = (op == OP_DEC_S) ? OP_DEC_U : OP_DEC_S;
      code = {!is_final || open_end, 7'($urandom)};
      send_beat(op, code, rand64(), is_final && (open_end || $urandom_range(0, 3) == 0));
      if (!is_final && $urandom_range(0, 19) == 0) send_encode();
    end
  endtask

  // Output side: random stalls, quiet stretches, and one long hold-off on request
  initial begin : sink
    int unsigned idle_pct;
    logic        held;
    idle_pct = 20;
    held     = 1'b0;
    m_tready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_off_req && !held) begin
        m_tready = 1'b0;
        repeat (400) @(negedge clk);
        held     = 1'b1;
        m_tready = 1'b1;
      end else if (!quiet && $urandom_range(0, 99) < idle_pct) begin
        m_tready = 1'b0;
        repeat ($urandom_range(0, 6)) @(negedge clk);
      end else begin
        m_tready = 1'b1;
      end
      if ($urandom_range(0, 63) == 0) idle_pct = $urandom_range(0, 2) * 25;
    end
  end

  // Stimulus and verdict
  initial begin : source
    logic        hold_done;
    logic        drain_done;
    int unsigned pick;
    rst_n        = 1'b0;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = OP_DEC_U;
    s_tlast      = 1'b0;
    quiet        = 1'b0;
    hold_off_req = 1'b0;
    src_idle_pct = 20;
    beats_sent   = 0;
    hold_done    = 1'b0;
    drain_done   = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Single-byte values, both signs
    send_beat(OP_DEC_U, 8'h00, '0, 1'b0);
    send_beat(OP_DEC_S, 8'h40, '1, 1'b0);
    // Multi-byte unsigned and signed values
    send_beat(OP_DEC_U, 8'hE5, '0, 1'b0);
    send_beat(OP_DEC_U, 8'h8E, '0, 1'b0);
    send_beat(OP_DEC_U, 8'h26, '0, 1'b0);
    send_beat(OP_DEC_S, 8'hC0, '1, 1'b0);
    send_beat(OP_DEC_S, 8'hBB, '1, 1'b0);
    send_beat(OP_DEC_S, 8'h78, '1, 1'b0);
    // Run out of buffer on a continuing byte
    send_beat(OP_DEC_U, 8'h80, '0, 1'b0);
    send_beat(OP_DEC_U, 8'h80, '0, 1'b1);
    // Terminating byte that is also the last in the buffer
    send_beat(OP_DEC_U, 8'h05, '0, 1'b1);
    // Encode in the middle of a pending value; finish it in signed mode
    send_beat(OP_DEC_U, 8'h81, '0, 1'b0);
    send_beat(OP_ENC_U, 8'hFF, 64'd300, 1'b0);
    send_beat(OP_DEC_S, 8'h7F, '0, 1'b0);
    // Continuing byte at the byte limit
    repeat (LEB_MAX_BYTES) send_beat(OP_DEC_U, 8'hFF, '1, 1'b0);
    // Encode extremes
    send_beat(OP_ENC_U, 8'h00, '1, 1'b0);
    send_beat(OP_ENC_U, 8'h00, '0, 1'b0);
    send_beat(OP_ENC_S, 8'h00, 64'h8000_0000_0000_0000, 1'b1);
    send_beat(OP_ENC_S, 8'h00, '1, 1'b0);

    // Random part
    while (beats_sent < 460) begin
      if (beats_sent > 400) quiet = 1'b1;
      if (!hold_done && beats_sent >= 150) begin
        hold_off_req = 1'b1;
        hold_done    = 1'b1;
      end
      if (!drain_done && beats_sent >= 300) begin
        s_tvalid = 1'b0;
        wait (pending == 0);
        repeat (8) @(negedge clk);
        drain_done = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        send_decode_run();
      end else if (pick < 85) begin
        send_encode();
      end else begin
        send_beat($urandom_range(0, 1) ? OP_DEC_S : OP_DEC_U, 8'($urandom), rand64(),
                  1'($urandom_range(0, 1)));
      end
    end
    s_tvalid = 1'b0;

    // Drain and settle
    wait (pending == 0);
    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/leb_pkg.sv
rtl/core/leb_shifter.sv
rtl/core/leb128_codec.sv
rtl/core/leb_checker.sv
tb/sv/leb128_result_checker.sv
tb/sv/tb_leb128_codec.sv
